### design/fdlm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdlm_pkg
// Shared widths, register indexes and helper types of the feedback delay
// line mixer.
// ----------------------------------------------------------------------------
package fdlm_pkg;

	localparam int CHANNELS_DEF  = 2;
	localparam int MAX_DELAY_DEF = 65536;

	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 25;
	localparam int GAIN_W   = 16;
	localparam int CFG_W    = 25;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W     = 18;
	localparam int ACC_W    = 34;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_AMOUNT    = 2'd2;

	localparam logic [CFG_W-1:0]  DELAY_RESET = 25'd8388608;
	localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd16384;
	localparam logic [GAIN_W-1:0] MIX_RESET   = 16'd16384;
	localparam logic [GAIN_W-1:0] UNITY       = 16'd32768;
	localparam logic [GAIN_W-1:0] HALF        = 16'd16384;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctrl_t;

	// saturate an accumulator-wide value to one sample
	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > ACC_W'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -ACC_W'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### design/fdlm_line_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdlm_line_mem
// Single-port sample memory holding the delay lines of all channels.
// ----------------------------------------------------------------------------
module fdlm_line_mem #(
	parameter int DEPTH  = 131076,
	parameter int ADDR_W = 18
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [ADDR_W-1:0]                    addr,
	input  wire logic signed [fdlm_pkg::SAMPLE_W-1:0] wdata,
	output logic signed [fdlm_pkg::SAMPLE_W-1:0]      rdata
);

	logic signed [fdlm_pkg::SAMPLE_W-1:0] mem [DEPTH];
	logic signed [fdlm_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### design/fdlm_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdlm_mac
// Shared signed multiply-accumulate unit used by every product of an item.
// ----------------------------------------------------------------------------
module fdlm_mac (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire fdlm_pkg::mac_ctrl_t              ctrl,
	input  wire logic signed [fdlm_pkg::OP_W-1:0] op_a,
	input  wire logic signed [fdlm_pkg::OP_W-1:0] op_b,
	output logic signed [fdlm_pkg::ACC_W-1:0]     acc
);

	logic signed [2*fdlm_pkg::OP_W-1:0] prod;
	logic signed [fdlm_pkg::ACC_W-1:0]  base;
	logic signed [fdlm_pkg::ACC_W-1:0]  acc_q;

	assign prod = op_a * op_b;
	assign base = ctrl.clr ? '0 : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.en) begin
			acc_q <= base + fdlm_pkg::ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

### design/feedback_delay_line_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_delay_line_mixer
// Feedback echo delay with interpolated read and dry/wet mix, per channel.
// ----------------------------------------------------------------------------
// One sample of one channel is taken per transfer and one mixed sample comes
// back for it. After reset the block first clears its delay memory, one entry
// per cycle, all CHANNELS*(MAX_DELAY+2) entries (131076 at the defaults);
// s_tready stays low during that pass while configuration writes are taken.
// Afterwards a sample steps through address, tap reads, interpolation,
// feedback, line write and mix, and no new input is taken before it is in
// the output register; this is set by the single multiplier (five products per
// sample) and the single memory port (two reads and one write per sample). A
// finished result waits in the output register while the next sample is taken.
module feedback_delay_line_mixer #(
	parameter int CHANNELS  = fdlm_pkg::CHANNELS_DEF,
	parameter int MAX_DELAY = fdlm_pkg::MAX_DELAY_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input sample stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [15:0]                       s_tdata,   // [15:0] sample_in
	input  wire logic [0:0]                        s_tuser,   // [0] chan
	// output sample stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [15:0]                            m_tdata,   // [15:0] sample_out
	output logic [0:0]                             m_tuser,   // [0] chan_out
	// register writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fdlm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fdlm_pkg::CFG_W-1:0]        cfg_data
);

	localparam int LINE_LEN = MAX_DELAY + 2;
	localparam int DEPTH    = CHANNELS * LINE_LEN;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DMAX     = MAX_DELAY * 256;
	localparam int POS_W    = fdlm_pkg::POS_W;
	localparam int ACC_W    = fdlm_pkg::ACC_W;
	localparam int OP_W     = fdlm_pkg::OP_W;
	localparam int SW       = fdlm_pkg::SAMPLE_W;

	// sequencer codes
	localparam logic [3:0] ST_CLR  = 4'd0;   // memory clearing pass
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_ADR  = 4'd2;   // line address and fraction
	localparam logic [3:0] ST_RDA  = 4'd3;   // read older tap
	localparam logic [3:0] ST_RDB  = 4'd4;   // read newer tap, a*(256-f)
	localparam logic [3:0] ST_MACB = 4'd5;   // + b*f
	localparam logic [3:0] ST_DLY  = 4'd6;   // round interpolated value
	localparam logic [3:0] ST_FB   = 4'd7;   // delayed*gain
	localparam logic [3:0] ST_WR   = 4'd8;   // write line, dry*x
	localparam logic [3:0] ST_MIX  = 4'd9;   // + wet*delayed
	localparam logic [3:0] ST_DONE = 4'd10;  // round, clip, hand to output

	logic [3:0] state_q;

	// configuration registers
	logic [fdlm_pkg::CFG_W-1:0]  delay_q;
	logic [fdlm_pkg::GAIN_W-1:0] gain_q;
	logic [fdlm_pkg::GAIN_W-1:0] mix_q;

	// per-item working registers
	logic [0:0]                  chan_q;
	logic [CH_W-1:0]             ch_q;
	logic signed [SW-1:0]        x_q;
	logic [POS_W-1:0]            pos_q;
	logic [POS_W:0]              pos_inc_q;
	logic [7:0]                  frac_q;
	logic [ADDR_W-1:0]           addr_q;
	logic signed [SW-1:0]        delayed_q;
	logic [ADDR_W-1:0]           clr_q;

	logic [POS_W-1:0]            position_q [CHANNELS];

	// output register
	logic                        out_valid_q;
	logic [15:0]                 out_data_q;
	logic [0:0]                  out_chan_q;

	// memory and mac connections
	logic                        mem_we;
	logic [ADDR_W-1:0]           mem_addr;
	logic signed [SW-1:0]        mem_wdata;
	logic signed [SW-1:0]        mem_rdata;
	fdlm_pkg::mac_ctrl_t         mac_ctrl;
	logic signed [OP_W-1:0]      op_a;
	logic signed [OP_W-1:0]      op_b;
	logic signed [ACC_W-1:0]     acc;

	logic                        in_xfer;
	logic [CH_W-1:0]             ch_in;
	logic [31:0]                 idx_wide;
	logic [31:0]                 idx_clamped;
	logic [POS_W:0]              dlen;
	logic [POS_W:0]              pos_next;
	logic [fdlm_pkg::GAIN_W-1:0] gain_c;
	logic [fdlm_pkg::GAIN_W-1:0] mix_c;
	logic [fdlm_pkg::GAIN_W:0]   dry;
	logic [fdlm_pkg::GAIN_W:0]   wet;
	logic [8:0]                  frac_inv;
	logic signed [ACC_W-1:0]     rnd8;
	logic signed [ACC_W-1:0]     rnd15;
	logic signed [ACC_W-1:0]     x_wide;
	logic                        out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;

	// channels beyond the configured count fall back to channel 0
	assign ch_in = ({31'd0, s_tuser} < CHANNELS) ? CH_W'(s_tuser) : '0;

	// delay clamped to one sample .. MAX_DELAY samples
	always_comb begin
		if (delay_q < 25'd256) begin
			dlen = 26'd256;
		end else if ({2'b0, delay_q} > 27'(DMAX)) begin
			dlen = (POS_W+1)'(DMAX);
		end else begin
			dlen = {1'b0, delay_q};
		end
	end

	assign idx_wide    = 32'(pos_q[POS_W-1:8]);
	assign idx_clamped = (idx_wide > 32'(MAX_DELAY)) ? 32'(MAX_DELAY) : idx_wide;
	assign pos_next    = (pos_inc_q >= dlen) ? (pos_inc_q - dlen) : pos_inc_q;

	// gains above unity act as unity; dry/wet from the mix share
	assign gain_c = (gain_q > fdlm_pkg::UNITY) ? fdlm_pkg::UNITY : gain_q;
	assign mix_c  = (mix_q > fdlm_pkg::UNITY) ? fdlm_pkg::UNITY : mix_q;
	assign wet    = (mix_c >= fdlm_pkg::HALF) ? {1'b0, fdlm_pkg::UNITY} : {mix_c, 1'b0};
	assign dry    = (mix_c <= fdlm_pkg::HALF) ? {1'b0, fdlm_pkg::UNITY}
	                                          : {(fdlm_pkg::UNITY - mix_c), 1'b0};

	assign frac_inv = 9'd256 - {1'b0, frac_q};
	assign rnd8     = (acc + ACC_W'(128)) >>> 8;
	assign rnd15    = (acc + ACC_W'(16384)) >>> 15;
	assign x_wide   = ACC_W'(x_q);

	// operand selection for the shared multiplier
	always_comb begin
		mac_ctrl = '0;
		op_a     = '0;
		op_b     = '0;
		case (state_q)
			ST_RDB: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				op_a     = OP_W'(mem_rdata);
				op_b     = $signed({{(OP_W-9){1'b0}}, frac_inv});
			end
			ST_MACB: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b0};
				op_a     = OP_W'(mem_rdata);
				op_b     = $signed({{(OP_W-8){1'b0}}, frac_q});
			end
			ST_FB: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				op_a     = OP_W'(delayed_q);
				op_b     = $signed({{(OP_W-fdlm_pkg::GAIN_W){1'b0}}, gain_c});
			end
			ST_WR: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b1};
				op_a     = OP_W'(x_q);
				op_b     = $signed({{(OP_W-fdlm_pkg::GAIN_W-1){1'b0}}, dry});
			end
			ST_MIX: begin
				mac_ctrl = '{en: 1'b1, clr: 1'b0};
				op_a     = OP_W'(delayed_q);
				op_b     = $signed({{(OP_W-fdlm_pkg::GAIN_W-1){1'b0}}, wet});
			end
			default: begin
				mac_ctrl = '0;
			end
		endcase
	end

	// single memory port: clearing, two tap reads, one line write
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = addr_q;
		mem_wdata = fdlm_pkg::sat16(x_wide + rnd15);
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			ST_RDB: begin
				mem_addr = addr_q + ADDR_W'(1);
			end
			ST_WR: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_addr = addr_q;
			end
		endcase
	end

	// result may enter the output register once the previous one is gone
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= fdlm_pkg::DELAY_RESET;
			gain_q  <= fdlm_pkg::GAIN_RESET;
			mix_q   <= fdlm_pkg::MIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fdlm_pkg::REG_DELAY_LENGTH:  delay_q <= cfg_data;
				fdlm_pkg::REG_FEEDBACK_GAIN: gain_q  <= cfg_data[fdlm_pkg::GAIN_W-1:0];
				fdlm_pkg::REG_MIX_AMOUNT:    mix_q   <= cfg_data[fdlm_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				position_q[c] <= '0;
			end
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_ADR;
					end
				end
				ST_ADR:  state_q <= ST_RDA;
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB: begin
					position_q[ch_q] <= pos_next[POS_W-1:0];
					state_q          <= ST_MACB;
				end
				ST_MACB: state_q <= ST_DLY;
				ST_DLY:  state_q <= ST_FB;
				ST_FB:   state_q <= ST_WR;
				ST_WR:   state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			chan_q <= s_tuser;
			ch_q   <= ch_in;
			x_q    <= $signed(s_tdata);
			pos_q  <= position_q[ch_in];
		end
		if (state_q == ST_ADR) begin
			addr_q    <= ADDR_W'(ch_q) * ADDR_W'(LINE_LEN) + ADDR_W'(idx_clamped);
			frac_q    <= pos_q[7:0];
			pos_inc_q <= {1'b0, pos_q} + (POS_W+1)'(256);
		end
		if (state_q == ST_DLY) begin
			delayed_q <= rnd8[SW-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= fdlm_pkg::sat16(rnd15);
			out_chan_q <= chan_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_chan_q;

	fdlm_line_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	fdlm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

endmodule
`default_nettype wire
